// ----- src/syr_pkg.sv -----
package syr_pkg;

    // Size limits of the scaler
    localparam int MAX_TARGET_WIDTH  = 1024;
    localparam int MAX_TARGET_HEIGHT = 1024;
    localparam int MAX_SOURCE_DIM    = 4096;
    localparam int MAX_TARGET_DIM    = (MAX_TARGET_WIDTH > MAX_TARGET_HEIGHT) ?
                                       MAX_TARGET_WIDTH : MAX_TARGET_HEIGHT;

    // Derived internal widths
    localparam int SRC_DIM_W = $clog2(MAX_SOURCE_DIM + 1);   // holds a source size
    localparam int SRC_IDX_W = $clog2(MAX_SOURCE_DIM);       // holds a source index
    localparam int TGT_DIM_W = $clog2(MAX_TARGET_DIM + 1);   // holds a target size
    localparam int TGT_IDX_W = $clog2(MAX_TARGET_DIM);       // holds a target index
    localparam int RS_W      = TGT_DIM_W + 1;                // remainder sum
    localparam int DIV_CNT_W = $clog2(SRC_DIM_W + 1);

    // Fixed field and register widths
    localparam int SRC_REG_W = 13;
    localparam int TGT_REG_W = 11;
    localparam int COORD_W   = 12;
    localparam int SAMPLE_W  = 8;
    localparam int PIXEL_W   = 16;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // Reset values of the registers
    localparam logic [SRC_REG_W-1:0] SRC_W_RST = 13'd1024;
    localparam logic [SRC_REG_W-1:0] SRC_H_RST = 13'd600;
    localparam logic [TGT_REG_W-1:0] TGT_W_RST = 11'd1024;
    localparam logic [TGT_REG_W-1:0] TGT_H_RST = 11'd600;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_SRC_W = 3'd0,
        REG_SRC_H = 3'd1,
        REG_TGT_W = 3'd2,
        REG_TGT_H = 3'd3,
        REG_SWAP  = 3'd4
    } syr_reg_t;

    // Q16 color coefficients, signed so they multiply signed chroma
    localparam int PROD_W = 27;
    localparam logic signed [17:0] CF_RV = 18'sd91881;
    localparam logic signed [17:0] CF_GU = 18'sd22554;
    localparam logic signed [17:0] CF_GV = 18'sd46802;
    localparam logic signed [17:0] CF_BU = 18'sd116130;
    localparam logic signed [8:0]  CHROMA_MID = 9'sd128;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Geometry and status from the register block to the front end
    typedef struct packed {
        logic [SRC_DIM_W-1:0] src_w;
        logic [SRC_DIM_W-1:0] src_h;
        logic [TGT_DIM_W-1:0] tgt_w;
        logic [TGT_DIM_W-1:0] tgt_h;
        logic [SRC_DIM_W-1:0] col_quot;
        logic [TGT_IDX_W-1:0] col_rem;
        logic [SRC_DIM_W-1:0] row_quot;
        logic [TGT_IDX_W-1:0] row_rem;
        logic                 busy;
        logic                 restart;
    } syr_geom_t;

    // One word in the queue between front and back
    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] chroma_blue;
        logic [SAMPLE_W-1:0] chroma_red;
        logic [COORD_W-1:0]  source_column;
        logic [COORD_W-1:0]  source_row;
        logic                end_of_line;
        logic                end_of_frame;
    } syr_item_t;

    // Zero acts as one, large values saturate
    function automatic logic [SRC_DIM_W-1:0] lim_src(input logic [SRC_REG_W-1:0] raw);
        logic [SRC_DIM_W-1:0] res;
        if (raw == '0)
            res = SRC_DIM_W'(1);
        else if (int'(raw) > MAX_SOURCE_DIM)
            res = SRC_DIM_W'(MAX_SOURCE_DIM);
        else
            res = SRC_DIM_W'(raw);
        return res;
    endfunction

    function automatic logic [TGT_DIM_W-1:0] lim_tgt(input logic [TGT_REG_W-1:0] raw,
                                                     input int hi);
        logic [TGT_DIM_W-1:0] res;
        if (raw == '0)
            res = TGT_DIM_W'(1);
        else if (int'(raw) > hi)
            res = TGT_DIM_W'(hi);
        else
            res = TGT_DIM_W'(raw);
        return res;
    endfunction

endpackage

// ----- src/syr_div.sv -----
module syr_div
    import syr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SRC_DIM_W-1:0] num,
    input  logic [TGT_DIM_W-1:0] den,
    output logic                 busy,
    output logic [SRC_DIM_W-1:0] quot,
    output logic [TGT_IDX_W-1:0] rem
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SRC_DIM_W-1:0] quo_reg;
    logic [TGT_DIM_W-1:0] rem_reg;
    logic [TGT_DIM_W-1:0] den_reg;
    logic [TGT_DIM_W:0]   trial;
    logic                 fits;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[SRC_DIM_W-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(SRC_DIM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[SRC_DIM_W-2:0], fits};
            rem_reg <= fits ? TGT_DIM_W'(trial - {1'b0, den_reg}) : TGT_DIM_W'(trial);
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quo_reg;
    assign rem  = TGT_IDX_W'(rem_reg);

endmodule

// ----- src/syr_cfg.sv -----
module syr_cfg
    import syr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output syr_geom_t         geom,
    output logic              swap
);

    logic [SRC_REG_W-1:0] src_w_reg;
    logic [SRC_REG_W-1:0] src_h_reg;
    logic [TGT_REG_W-1:0] tgt_w_reg;
    logic [TGT_REG_W-1:0] tgt_h_reg;
    logic                 swap_reg;
    logic                 div_start_reg;
    logic                 wr;
    logic                 size_wr;
    logic [2:0]           idx;
    logic                 col_busy;
    logic                 row_busy;
    logic [SRC_DIM_W-1:0] src_w_eff;
    logic [SRC_DIM_W-1:0] src_h_eff;
    logic [TGT_DIM_W-1:0] tgt_w_eff;
    logic [TGT_DIM_W-1:0] tgt_h_eff;

    // Write decode
    assign idx     = paddr[ADDR_W-1:2];
    assign wr      = psel && penable && pwrite;
    assign size_wr = wr && (idx == REG_SRC_W || idx == REG_SRC_H ||
                            idx == REG_TGT_W || idx == REG_TGT_H);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SRC_W_RST;
            src_h_reg <= SRC_H_RST;
            tgt_w_reg <= TGT_W_RST;
            tgt_h_reg <= TGT_H_RST;
            swap_reg  <= 1'b0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_SRC_W: src_w_reg <= pwdata[SRC_REG_W-1:0];
                REG_SRC_H: src_h_reg <= pwdata[SRC_REG_W-1:0];
                REG_TGT_W: tgt_w_reg <= pwdata[TGT_REG_W-1:0];
                REG_TGT_H: tgt_h_reg <= pwdata[TGT_REG_W-1:0];
                REG_SWAP:  swap_reg  <= pwdata[0];
                default:   ;
            endcase
        end
    end

    // Step divisions rerun after reset and after every size write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_start_reg <= 1'b1;
        end
        else
        begin
            div_start_reg <= size_wr;
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_SRC_W: prdata = DATA_W'(src_w_reg);
            REG_SRC_H: prdata = DATA_W'(src_h_reg);
            REG_TGT_W: prdata = DATA_W'(tgt_w_reg);
            REG_TGT_H: prdata = DATA_W'(tgt_h_reg);
            REG_SWAP:  prdata = DATA_W'(swap_reg);
            default:   prdata = '0;
        endcase
    end

    // Effective sizes
    assign src_w_eff = lim_src(src_w_reg);
    assign src_h_eff = lim_src(src_h_reg);
    assign tgt_w_eff = lim_tgt(tgt_w_reg, MAX_TARGET_WIDTH);
    assign tgt_h_eff = lim_tgt(tgt_h_reg, MAX_TARGET_HEIGHT);

    syr_div u_col_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (src_w_eff),
        .den   (tgt_w_eff),
        .busy  (col_busy),
        .quot  (geom.col_quot),
        .rem   (geom.col_rem)
    );

    syr_div u_row_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (src_h_eff),
        .den   (tgt_h_eff),
        .busy  (row_busy),
        .quot  (geom.row_quot),
        .rem   (geom.row_rem)
    );

    assign geom.src_w   = src_w_eff;
    assign geom.src_h   = src_h_eff;
    assign geom.tgt_w   = tgt_w_eff;
    assign geom.tgt_h   = tgt_h_eff;
    assign geom.busy    = div_start_reg || col_busy || row_busy;
    assign geom.restart = size_wr;
    assign swap         = swap_reg;

endmodule

// ----- src/syr_front.sv -----
module syr_front
    import syr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  syr_geom_t           geom,
    input  logic                push,
    output logic                full,
    input  logic [SAMPLE_W-1:0] luma,
    input  logic [SAMPLE_W-1:0] chroma_blue,
    input  logic [SAMPLE_W-1:0] chroma_red,
    input  logic                q_full,
    output logic                q_push,
    output syr_item_t           q_wdata
);

    logic [TGT_IDX_W-1:0] col_reg;
    logic [TGT_IDX_W-1:0] row_reg;
    logic [SRC_IDX_W-1:0] cacc_reg;
    logic [TGT_IDX_W-1:0] crem_reg;
    logic [SRC_IDX_W-1:0] racc_reg;
    logic [TGT_IDX_W-1:0] rrem_reg;

    logic                 accept;
    logic                 eol;
    logic                 eof;
    logic [SRC_DIM_W-1:0] sx;
    logic [SRC_DIM_W-1:0] sy;
    logic [RS_W-1:0]      col_sum;
    logic [RS_W-1:0]      row_sum;
    logic                 col_carry;
    logic                 row_carry;
    logic [TGT_IDX_W-1:0] crem_next;
    logic [TGT_IDX_W-1:0] rrem_next;
    logic [SRC_IDX_W-1:0] cacc_next;
    logic [SRC_IDX_W-1:0] racc_next;

    assign full   = q_full || geom.busy;
    assign accept = push && !full;

    // Classify: line and frame ends, clamped source coordinate
    always_comb
    begin
        eol = TGT_DIM_W'(col_reg) >= geom.tgt_w - TGT_DIM_W'(1);
        eof = eol && (TGT_DIM_W'(row_reg) >= geom.tgt_h - TGT_DIM_W'(1));
        sx  = (SRC_DIM_W'(cacc_reg) >= geom.src_w) ? geom.src_w - SRC_DIM_W'(1)
                                                   : SRC_DIM_W'(cacc_reg);
        sy  = (SRC_DIM_W'(racc_reg) >= geom.src_h) ? geom.src_h - SRC_DIM_W'(1)
                                                   : SRC_DIM_W'(racc_reg);
    end

    // Step accumulators: integer part plus remainder below the target size
    always_comb
    begin
        col_sum   = RS_W'(crem_reg) + RS_W'(geom.col_rem);
        col_carry = col_sum >= RS_W'(geom.tgt_w);
        crem_next = col_carry ? TGT_IDX_W'(col_sum - RS_W'(geom.tgt_w))
                              : TGT_IDX_W'(col_sum);
        cacc_next = SRC_IDX_W'(SRC_DIM_W'(cacc_reg) + geom.col_quot
                               + SRC_DIM_W'(col_carry));

        row_sum   = RS_W'(rrem_reg) + RS_W'(geom.row_rem);
        row_carry = row_sum >= RS_W'(geom.tgt_h);
        rrem_next = row_carry ? TGT_IDX_W'(row_sum - RS_W'(geom.tgt_h))
                              : TGT_IDX_W'(row_sum);
        racc_next = SRC_IDX_W'(SRC_DIM_W'(racc_reg) + geom.row_quot
                               + SRC_DIM_W'(row_carry));
    end

    // Raster state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cacc_reg <= '0;
            crem_reg <= '0;
            racc_reg <= '0;
            rrem_reg <= '0;
        end
        else if (geom.restart)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cacc_reg <= '0;
            crem_reg <= '0;
            racc_reg <= '0;
            rrem_reg <= '0;
        end
        else if (accept)
        begin
            priority if (eof)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                cacc_reg <= '0;
                crem_reg <= '0;
                racc_reg <= '0;
                rrem_reg <= '0;
            end
            else if (eol)
            begin
                col_reg  <= '0;
                cacc_reg <= '0;
                crem_reg <= '0;
                row_reg  <= row_reg + TGT_IDX_W'(1);
                racc_reg <= racc_next;
                rrem_reg <= rrem_next;
            end
            else
            begin
                col_reg  <= col_reg + TGT_IDX_W'(1);
                cacc_reg <= cacc_next;
                crem_reg <= crem_next;
            end
        end
    end

    // Word handed to the back end
    assign q_push                = accept;
    assign q_wdata.luma          = luma;
    assign q_wdata.chroma_blue   = chroma_blue;
    assign q_wdata.chroma_red    = chroma_red;
    assign q_wdata.source_column = COORD_W'(sx);
    assign q_wdata.source_row    = COORD_W'(sy);
    assign q_wdata.end_of_line   = eol;
    assign q_wdata.end_of_frame  = eof;

endmodule

// ----- src/syr_fifo.sv -----
module syr_fifo
    import syr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  syr_item_t wdata,
    output logic      full,
    input  logic      pop,
    output syr_item_t rdata,
    output logic      empty
);

    syr_item_t            mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   wptr_reg;
    logic [Q_PTR_W-1:0]   rptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (cnt_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rptr_reg <= rptr_reg + Q_PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= wdata;
    end

endmodule

// ----- src/syr_back.sv -----
module syr_back
    import syr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               swap,
    input  logic               q_empty,
    input  syr_item_t          q_rdata,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [PIXEL_W-1:0] pixel,
    output logic [COORD_W-1:0] source_column,
    output logic [COORD_W-1:0] source_row,
    output logic               end_of_line,
    output logic               end_of_frame
);

    // Stage 1: chroma products
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] p_rv_reg;
    logic signed [PROD_W-1:0] p_gu_reg;
    logic signed [PROD_W-1:0] p_gv_reg;
    logic signed [PROD_W-1:0] p_bu_reg;
    logic [SAMPLE_W-1:0]      s1_luma_reg;
    logic [COORD_W-1:0]       s1_col_reg;
    logic [COORD_W-1:0]       s1_row_reg;
    logic                     s1_eol_reg;
    logic                     s1_eof_reg;

    // Output register
    logic                     out_valid_reg;
    logic [PIXEL_W-1:0]       pixel_reg;
    logic [COORD_W-1:0]       col_reg;
    logic [COORD_W-1:0]       row_reg;
    logic                     eol_reg;
    logic                     eof_reg;

    logic                     out_en;
    logic                     s1_en;
    logic signed [8:0]        du;
    logic signed [8:0]        dv;
    logic signed [PROD_W-1:0] y_q16;
    logic signed [PROD_W-1:0] sum_r;
    logic signed [PROD_W-1:0] sum_g;
    logic signed [PROD_W-1:0] sum_b;
    logic [7:0]               r8;
    logic [7:0]               g8;
    logic [7:0]               b8;
    logic [PIXEL_W-1:0]       px;

    // Truncate Q16 sum, clamp to 0..255
    function automatic logic [7:0] clamp8(input logic signed [PROD_W-1:0] s);
        logic [7:0] res;
        if (s[PROD_W-1])
            res = 8'd0;
        else if (s[PROD_W-2:16] > (PROD_W-17)'(255))
            res = 8'd255;
        else
            res = s[23:16];
        return res;
    endfunction

    // Stage enables: output slot frees on pop, stage 1 refills when it moves
    assign out_en = !out_valid_reg || pop;
    assign s1_en  = !s1_valid_reg || out_en;
    assign q_pop  = s1_en && !q_empty;

    assign du = $signed({1'b0, q_rdata.chroma_blue}) - CHROMA_MID;
    assign dv = $signed({1'b0, q_rdata.chroma_red}) - CHROMA_MID;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= !q_empty;
            if (out_en)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_rv_reg    <= PROD_W'(CF_RV) * PROD_W'(dv);
            p_gu_reg    <= PROD_W'(CF_GU) * PROD_W'(du);
            p_gv_reg    <= PROD_W'(CF_GV) * PROD_W'(dv);
            p_bu_reg    <= PROD_W'(CF_BU) * PROD_W'(du);
            s1_luma_reg <= q_rdata.luma;
            s1_col_reg  <= q_rdata.source_column;
            s1_row_reg  <= q_rdata.source_row;
            s1_eol_reg  <= q_rdata.end_of_line;
            s1_eof_reg  <= q_rdata.end_of_frame;
        end
    end

    // Stage 2: channel sums, clamp and pack
    always_comb
    begin
        y_q16 = $signed({{(PROD_W-24){1'b0}}, s1_luma_reg, 16'd0});
        sum_r = y_q16 + p_rv_reg;
        sum_g = y_q16 - p_gu_reg - p_gv_reg;
        sum_b = y_q16 + p_bu_reg;
        r8    = clamp8(sum_r);
        g8    = clamp8(sum_g);
        b8    = clamp8(sum_b);
        if (swap)
            px = {b8[7:3], g8[7:2], r8[7:3]};
        else
            px = {r8[7:3], g8[7:2], b8[7:3]};
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            pixel_reg <= px;
            col_reg   <= s1_col_reg;
            row_reg   <= s1_row_reg;
            eol_reg   <= s1_eol_reg;
            eof_reg   <= s1_eof_reg;
        end
    end

    assign empty         = !out_valid_reg;
    assign pixel         = pixel_reg;
    assign source_column = col_reg;
    assign source_row    = row_reg;
    assign end_of_line   = eol_reg;
    assign end_of_frame  = eof_reg;

endmodule

// ----- src/scaled_yuv_to_rgb565.sv -----
// Nearest-neighbor scaler stage with full-range YUV to RGB565 conversion.
// Input queue port: push/full carries one word of Y, U and V samples per
// output pixel, in raster order over the target picture. Result queue port:
// empty/pop shows the packed pixel, its source column and row, and
// end-of-line / end-of-frame marks; the oldest word sits on the ports while
// empty is low.
// Sizes and the red/blue swap are set over the APB port (4 bytes apart).
// Throughput: one word per clock while full is low and pop keeps up. A pushed
// word passes the front queue, the chroma product stage and the output register.
// Source coordinates come from step accumulators; the per-axis step
// (source size / target size) is found by two restoring dividers that rerun
// after reset and after every size write, with full high meanwhile.
// Reset returns all registers to their defaults, empties both queues and
// starts the raster at pixel (0,0). A size write also restarts the raster.
// When pop stays low the output register holds, the 4-deep front queue
// fills and full rises; nothing is dropped.
module scaled_yuv_to_rgb565
    import syr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [SAMPLE_W-1:0] luma,
    input  logic [SAMPLE_W-1:0] chroma_blue,
    input  logic [SAMPLE_W-1:0] chroma_red,
    output logic                empty,
    input  logic                pop,
    output logic [PIXEL_W-1:0]  pixel,
    output logic [COORD_W-1:0]  source_column,
    output logic [COORD_W-1:0]  source_row,
    output logic                end_of_line,
    output logic                end_of_frame,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    syr_geom_t geom;
    logic      swap;
    logic      q_full;
    logic      q_push;
    syr_item_t q_wdata;
    logic      q_empty;
    logic      q_pop;
    syr_item_t q_rdata;

    assign pready = 1'b1;

    syr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .geom    (geom),
        .swap    (swap)
    );

    syr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .push        (push),
        .full        (full),
        .luma        (luma),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    syr_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    syr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .swap          (swap),
        .q_empty       (q_empty),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .pixel         (pixel),
        .source_column (source_column),
        .source_row    (source_row),
        .end_of_line   (end_of_line),
        .end_of_frame  (end_of_frame)
    );

endmodule

// ----- src/syr_chk.sv -----
module syr_chk
    import syr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [PIXEL_W-1:0] pixel,
    input logic               end_of_line,
    input logic               end_of_frame,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic               pready,
    input logic [ADDR_W-1:0]  paddr
);

    // In the cycle after reset is sampled low nothing is taken in and nothing is offered
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> (full && empty))
        else $error("full/empty wrong during reset");

    // A frame end is always also a line end
    a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_frame) |-> end_of_line)
        else $error("end_of_frame without end_of_line");

    // A size write blocks input while the step dividers rerun
    a_size_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] <= REG_TGT_H))
        |=> full)
        else $error("input not held off after size write");

    // A result not taken stays on the ports
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel) && $stable(end_of_line)))
        else $error("waiting result changed");

endmodule

bind scaled_yuv_to_rgb565 syr_chk u_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .pixel        (pixel),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr)
);
